[rtl/sobel_edge_threshold_top_macros.svh]
// Assertion macros used by the Sobel edge threshold top level.
`ifndef SOBEL_EDGE_THRESHOLD_TOP_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/set_pkg.sv]
// Types and constants for the Sobel edge threshold block.
package set_pkg;

    localparam int PIX_W     = 8;
    localparam int THR_W     = 11;
    localparam int WID_W     = 11;
    localparam int HGT_W     = 12;
    localparam int CFG_W     = 12;
    localparam int OUT_COL_W = 10;
    localparam int DIM_W     = 13;
    localparam int SUM_W     = 10;
    localparam int MAG_W     = 11;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [THR_W-1:0] THR_RST = 11'd128;
    localparam logic [WID_W-1:0] WID_RST = 11'd868;
    localparam logic [HGT_W-1:0] HGT_RST = 12'd600;
    localparam logic [HGT_W-1:0] MIN_DIM = 12'd3;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_idx_t;

    // One entry of the line store: the two rows above the current one.
    typedef struct packed {
        logic [PIX_W-1:0] two_up;
        logic [PIX_W-1:0] one_up;
    } line_pair_t;

    // Newest window column, top to bottom.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } win_col_t;

endpackage

[rtl/set_line_buf.sv]
// Two-row line store: one registered read and one write per cycle.
module set_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output set_pkg::line_pair_t         rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  set_pkg::line_pair_t         wr_data
);

    set_pkg::line_pair_t mem [MAX_WIDTH];
    set_pkg::line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/set_window.sv]
// 3x3 window registers and the Sobel L1 magnitude compare.
module set_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  set_pkg::win_col_t           col,
    input  logic [set_pkg::THR_W-1:0]   threshold,
    output logic                        edge_hit
);

    // Two previous columns: [0]/[1] top row, [2]/[3] middle, [4]/[5] bottom.
    logic [set_pkg::PIX_W-1:0] win_reg [6];

    logic [set_pkg::SUM_W-1:0] sum_a, sum_b, sum_l, sum_r;
    logic signed [set_pkg::SUM_W:0] gx, gy;
    logic [set_pkg::SUM_W-1:0] abs_x, abs_y;
    logic [set_pkg::MAG_W-1:0] mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= col.top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= col.mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= col.bot;
        end
    end

    always_comb
    begin
        sum_a = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, col.top};
        sum_b = {2'b00, win_reg[4]} + {1'b0, win_reg[5], 1'b0} + {2'b00, col.bot};
        sum_l = {2'b00, win_reg[0]} + {1'b0, win_reg[2], 1'b0} + {2'b00, win_reg[4]};
        sum_r = {2'b00, col.top} + {1'b0, col.mid, 1'b0} + {2'b00, col.bot};
        gx = $signed({1'b0, sum_b}) - $signed({1'b0, sum_a});
        gy = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        abs_x = gx[set_pkg::SUM_W] ? set_pkg::SUM_W'(-gx) : gx[set_pkg::SUM_W-1:0];
        abs_y = gy[set_pkg::SUM_W] ? set_pkg::SUM_W'(-gy) : gy[set_pkg::SUM_W-1:0];
        mag = {1'b0, abs_x} + {1'b0, abs_y};
        edge_hit = (mag >= threshold);
    end

endmodule

[rtl/sobel_edge_threshold_top.sv]
// Sobel 3x3 edge marker with L1 magnitude threshold, top level.
// Grey pixels enter in raster order at one per clock while pixel_stall is
// low. A result reaches the result register by way of the window stage:
// accepting a pixel reads the line store into the window stage, and when
// the item leaves it, the window and magnitude compare go into the result
// register. A pixel at row r, column c with r and c at least 1 yields the
// mark (0 or 255) for centre (r-1, c-1); others yield nothing, so the last
// row and column are never produced. Centres on the first row or column
// are 0. frame_last flags the result for centre (height-2, width-2). The
// line store has one read and one write port, which sets the rate at one
// pixel per cycle; output stall backs up into pixel_stall only when the
// result register is full. Width is clamped to 3..MAX_WIDTH, height to 3
// and up; change configuration only between items.
`include "sobel_edge_threshold_top_macros.svh"

module sobel_edge_threshold_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [set_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [set_pkg::PIX_W-1:0]     pixel,
    output logic                          edge_valid,
    input  logic                          edge_stall,
    output logic [set_pkg::PIX_W-1:0]     edge_res,
    output logic [set_pkg::HGT_W-1:0]     center_row,
    output logic [set_pkg::OUT_COL_W-1:0] center_col,
    output logic                          frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam logic [set_pkg::DIM_W-1:0] MAX_W = set_pkg::DIM_W'(MAX_WIDTH);

    // configuration
    logic [set_pkg::THR_W-1:0] thr_reg;
    logic [set_pkg::WID_W-1:0] wid_reg;
    logic [set_pkg::HGT_W-1:0] hgt_reg;

    // position of the next pixel
    logic [COL_W-1:0]          col_reg, col_next;
    logic [set_pkg::HGT_W-1:0] row_reg, row_next;

    logic [set_pkg::DIM_W-1:0] w_eff;
    logic [set_pkg::HGT_W-1:0] h_eff;
    logic row_end, frame_end;

    // window stage
    logic                      s1_vld_reg;
    logic [set_pkg::PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [set_pkg::HGT_W-1:0] s1_row_reg;
    logic                      s1_emit_reg;
    logic                      s1_inner_reg;
    logic                      s1_last_reg;

    // result register
    logic                          out_vld_reg;
    logic [set_pkg::PIX_W-1:0]     edge_reg;
    logic [set_pkg::HGT_W-1:0]     crow_reg;
    logic [set_pkg::OUT_COL_W-1:0] ccol_reg;
    logic                          last_reg;

    logic pix_acc, out_ready, s1_go;
    logic [set_pkg::DIM_W-1:0] col_m1;

    set_pkg::line_pair_t rd_pair;
    set_pkg::line_pair_t wr_pair;
    set_pkg::win_col_t   win_col;
    logic                edge_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= set_pkg::THR_RST;
            wid_reg <= set_pkg::WID_RST;
            hgt_reg <= set_pkg::HGT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                set_pkg::CFG_THRESHOLD: thr_reg <= cfg_data[set_pkg::THR_W-1:0];
                set_pkg::CFG_WIDTH:     wid_reg <= cfg_data[set_pkg::WID_W-1:0];
                set_pkg::CFG_HEIGHT:    hgt_reg <= cfg_data[set_pkg::HGT_W-1:0];
                default:                ;
            endcase
        end
    end

    // handshake
    always_comb
    begin
        out_ready   = !out_vld_reg || !edge_stall;
        s1_go       = s1_vld_reg && (!s1_emit_reg || out_ready);
        pixel_stall = s1_vld_reg && !s1_go;
        pix_acc     = pixel_valid && !pixel_stall;
    end

    // clamp frame size and advance the position counters
    always_comb
    begin
        if (set_pkg::DIM_W'(wid_reg) < set_pkg::DIM_W'(set_pkg::MIN_DIM))
        begin
            w_eff = set_pkg::DIM_W'(set_pkg::MIN_DIM);
        end
        else if (set_pkg::DIM_W'(wid_reg) > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = set_pkg::DIM_W'(wid_reg);
        end
        h_eff     = (hgt_reg < set_pkg::MIN_DIM) ? set_pkg::MIN_DIM : hgt_reg;
        row_end   = set_pkg::DIM_W'(col_reg) >= (w_eff - set_pkg::DIM_W'(1));
        frame_end = row_end && (row_reg >= (h_eff - set_pkg::HGT_W'(1)));
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + set_pkg::HGT_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    set_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (pix_acc),
        .rd_addr (col_reg),
        .rd_data (rd_pair),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair)
    );

    // shift the column down one row as the item leaves the window stage
    always_comb
    begin
        wr_pair.two_up = rd_pair.one_up;
        wr_pair.one_up = s1_pix_reg;
        win_col.top    = rd_pair.two_up;
        win_col.mid    = rd_pair.one_up;
        win_col.bot    = s1_pix_reg;
    end

    set_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (s1_go),
        .col       (win_col),
        .threshold (thr_reg),
        .edge_hit  (edge_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (pix_acc)
        begin
            s1_vld_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pix_reg   <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_emit_reg  <= (row_reg != '0) && (col_reg != '0);
            s1_inner_reg <= (row_reg >= set_pkg::HGT_W'(2)) && (col_reg >= COL_W'(2));
            s1_last_reg  <= frame_end;
        end
    end

    assign col_m1 = set_pkg::DIM_W'(s1_col_reg) - set_pkg::DIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_vld_reg <= s1_go && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_go && s1_emit_reg)
        begin
            edge_reg <= (s1_inner_reg && edge_hit) ? set_pkg::EDGE_ON : set_pkg::EDGE_OFF;
            crow_reg <= s1_row_reg - set_pkg::HGT_W'(1);
            ccol_reg <= col_m1[set_pkg::OUT_COL_W-1:0];
            last_reg <= s1_last_reg;
        end
    end

    assign edge_valid = out_vld_reg;
    assign edge_res   = edge_reg;
    assign center_row = crow_reg;
    assign center_col = ccol_reg;
    assign frame_last = last_reg;

    `SET_ASSERT_NOW(a_edge_binary, edge_valid,
        edge_res == set_pkg::EDGE_ON || edge_res == set_pkg::EDGE_OFF,
        "edge result is neither 0 nor 255")
    `SET_ASSERT_NOW(a_silent_never_stalls, s1_vld_reg && !s1_emit_reg, s1_go,
        "item with no result held in window stage")
    `SET_ASSERT_NEXT(a_accept_fills_stage, pix_acc, s1_vld_reg,
        "accepted pixel did not reach window stage")
    `SET_ASSERT_NOW(a_stall_only_when_full, pixel_stall,
        s1_vld_reg && s1_emit_reg && out_vld_reg && edge_stall,
        "input stalled while result path is free")

endmodule
